// ----- src/ppc_pkg.sv -----
// Shared types and constants for the position PID controller.
`default_nettype none

package ppc_pkg;

   localparam int unsigned CPR_DEFAULT = 1336;
   localparam int unsigned DEG_SCALE   = 92160;  // 360 degrees times 256

   localparam int unsigned MUL_W  = 33;
   localparam int unsigned PROD_W = 2 * MUL_W;
   localparam int unsigned ACC_W  = 50;

   localparam int unsigned ANGLE_W = 24;
   localparam logic [31:0] ANGLE_POS_LIM = (32'd1 << (ANGLE_W - 1)) - 32'd1;
   localparam logic [31:0] ANGLE_NEG_LIM = 32'd1 << (ANGLE_W - 1);

   localparam logic [1:0] ACT_IDLE  = 2'd0;
   localparam logic [1:0] ACT_HOLD  = 2'd1;
   localparam logic [1:0] ACT_TRACK = 2'd2;

   localparam logic [1:0] CSR_GAIN_P      = 2'd0;
   localparam logic [1:0] CSR_GAIN_I      = 2'd1;
   localparam logic [1:0] CSR_GAIN_D      = 2'd2;
   localparam logic [1:0] CSR_HOLD_TARGET = 2'd3;

   typedef struct packed {
      logic [1:0]         action;
      logic signed [15:0] encoder_count;
      logic signed [23:0] track_reference;
   } req_type;

   typedef struct packed {
      logic signed [23:0] commanded_current;
      logic signed [23:0] measured_angle;
      logic signed [23:0] reference_used;
   } rsp_type;

endpackage

`default_nettype wire

// ----- src/ppc_mult.sv -----
// Shared signed multiplier with a registered product.
`default_nettype none

module ppc_mult import ppc_pkg::*; (
   input  wire logic                     clock,
   input  wire logic signed [MUL_W-1:0]  op_a,
   input  wire logic signed [MUL_W-1:0]  op_b,
   output logic signed [PROD_W-1:0]      product
);

   logic signed [PROD_W-1:0] product_ff;
   logic signed [PROD_W-1:0] product_in;

   assign product_in = PROD_W'(op_a) * PROD_W'(op_b);

   always_ff @(posedge clock) begin
      product_ff <= product_in;
   end

   assign product = product_ff;

endmodule

`default_nettype wire

// ----- src/position_pid_controller_top.sv -----
// Position PID controller: angle scaling, error, integral, derivative, command.
// Hold and track pass through every sequencer state; idle ticks skip the gain steps,
// and the output step waits while rsp_stall holds the previous result.
// Requests stall until the previous transaction is done; one 33x33 multiplier is
// shared by the three angle-scaling products and the three gain products.
// Reset (synchronous): gains 1.0/0/0, hold target 0, loop state cleared, ready at once.
`default_nettype none

module position_pid_controller_top import ppc_pkg::*; #(
   parameter int unsigned COUNTS_PER_REV = CPR_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire req_type     req_data,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output rsp_type          rsp_data,
   input  wire logic        csr_wr_en,
   input  wire logic [1:0]  csr_index,
   input  wire logic [23:0] csr_wdata
);

   // ceil(2^32 / N): quotient estimate is exact or one too large
   localparam longint unsigned RECIP = ((64'd1 << 32) + 64'(COUNTS_PER_REV) - 64'd1)
                                       / 64'(COUNTS_PER_REV);
   localparam logic [MUL_W-1:0] RECIP_C = MUL_W'(RECIP);
   localparam logic [MUL_W-1:0] CPR_C   = MUL_W'(COUNTS_PER_REV);
   localparam logic [33:0]      CPR_34  = 34'(COUNTS_PER_REV);
   localparam logic [17:0]      CPR_18  = 18'(COUNTS_PER_REV);

   typedef enum logic [10:0] {
      ST_IDLE  = 11'b00000000001,
      ST_MUL_A = 11'b00000000010,
      ST_MUL_Q = 11'b00000000100,
      ST_MUL_R = 11'b00000001000,
      ST_FIX   = 11'b00000010000,
      ST_ERR   = 11'b00000100000,
      ST_MP    = 11'b00001000000,
      ST_MI    = 11'b00010000000,
      ST_MD    = 11'b00100000000,
      ST_SUM   = 11'b01000000000,
      ST_OUT   = 11'b10000000000
   } state_type;

   state_type state_ff, state_in;

   logic signed [15:0] gain_p_ff, gain_i_ff, gain_d_ff;
   logic signed [23:0] hold_ff;

   logic               run_ff, run_in;
   logic               hold_sel_ff, hold_sel_in;
   logic               neg_ff, neg_in;
   logic [16:0]        mag_ff, mag_in;
   logic signed [23:0] track_ff, track_in;
   logic [31:0]        a_ff, a_in;
   logic [31:0]        q0_ff, q0_in;
   logic signed [23:0] angle_ff, angle_in;
   logic signed [23:0] ref_ff, ref_in;
   logic signed [24:0] err_ff, err_in;
   logic signed [25:0] edot_ff, edot_in;
   logic signed [ACC_W-1:0] acc_ff, acc_in;

   logic signed [31:0] integ_ff, integ_in;
   logic signed [24:0] prev_ff, prev_in;
   logic signed [23:0] held_ff, held_in;

   rsp_type            rsp_ff, rsp_in;
   logic               rsp_valid_ff, rsp_valid_in;

   logic signed [MUL_W-1:0]  mul_a, mul_b;
   logic signed [PROD_W-1:0] mul_p;

   logic                     req_fire;
   logic signed [33:0]       rem_raw;
   logic [31:0]              quo_adj;
   logic [16:0]              rem_adj;
   logic                     round_up;
   logic [31:0]              quo_rnd;
   logic signed [23:0]       angle_fix;
   logic signed [23:0]       ref_sel;
   logic signed [24:0]       err_calc;
   logic signed [32:0]       integ_sum;
   logic signed [31:0]       integ_sat;
   logic signed [ACC_W-1:0]  acc_sum;
   logic signed [ACC_W-9:0]  acc_shift;
   logic signed [23:0]       cmd_sat;

   ppc_mult u_mult (
      .clock   (clock),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .product (mul_p)
   );

   assign req_fire  = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // remainder of A - q0*N, then step back once and round half away from zero
   assign rem_raw = $signed({2'b00, a_ff}) - $signed(mul_p[33:0]);

   always_comb begin
      if (rem_raw[33]) begin
         quo_adj = q0_ff - 32'd1;
         rem_adj = 17'(rem_raw + $signed(CPR_34));
      end else begin
         quo_adj = q0_ff;
         rem_adj = rem_raw[16:0];
      end
   end

   assign round_up = ({rem_adj, 1'b0} >= CPR_18);
   assign quo_rnd  = quo_adj + 32'(round_up);

   always_comb begin
      if (neg_ff) begin
         angle_fix = (quo_rnd > ANGLE_NEG_LIM) ? 24'sh800000 : 24'(-quo_rnd);
      end else begin
         angle_fix = (quo_rnd > ANGLE_POS_LIM) ? 24'sh7FFFFF : quo_rnd[23:0];
      end
   end

   assign ref_sel   = hold_sel_ff ? hold_ff : track_ff;
   assign err_calc  = $signed({ref_sel[23], ref_sel}) - $signed({angle_ff[23], angle_ff});
   assign integ_sum = $signed({integ_ff[31], integ_ff}) + 33'(err_ff);
   assign integ_sat = (integ_sum[32] != integ_sum[31]) ?
                      (integ_sum[32] ? 32'sh80000000 : 32'sh7FFFFFFF) : integ_sum[31:0];

   assign acc_sum   = acc_ff + $signed(mul_p[ACC_W-1:0]);
   assign acc_shift = acc_sum[ACC_W-1:8];

   always_comb begin
      if ((&acc_shift[ACC_W-9:23]) || !(|acc_shift[ACC_W-9:23])) begin
         cmd_sat = acc_shift[23:0];
      end else begin
         cmd_sat = acc_shift[ACC_W-9] ? 24'sh800000 : 24'sh7FFFFF;
      end
   end

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         ST_MUL_A: begin
            mul_a = $signed(MUL_W'(mag_ff));
            mul_b = $signed(MUL_W'(DEG_SCALE));
         end
         ST_MUL_Q: begin
            mul_a = $signed({1'b0, mul_p[31:0]});
            mul_b = $signed(RECIP_C);
         end
         ST_MUL_R: begin
            mul_a = $signed({1'b0, mul_p[63:32]});
            mul_b = $signed(CPR_C);
         end
         ST_MP: begin
            mul_a = MUL_W'(gain_p_ff);
            mul_b = MUL_W'(err_ff);
         end
         ST_MI: begin
            mul_a = MUL_W'(gain_i_ff);
            mul_b = MUL_W'(integ_ff);
         end
         ST_MD: begin
            mul_a = MUL_W'(gain_d_ff);
            mul_b = MUL_W'(edot_ff);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      run_in       = run_ff;
      hold_sel_in  = hold_sel_ff;
      neg_in       = neg_ff;
      mag_in       = mag_ff;
      track_in     = track_ff;
      a_in         = a_ff;
      q0_in        = q0_ff;
      angle_in     = angle_ff;
      ref_in       = ref_ff;
      err_in       = err_ff;
      edot_in      = edot_ff;
      acc_in       = acc_ff;
      integ_in     = integ_ff;
      prev_in      = prev_ff;
      held_in      = held_ff;
      rsp_in       = rsp_ff;
      // drop the result once the consumer takes it
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               run_in      = req_data.action inside {ACT_HOLD, ACT_TRACK};
               hold_sel_in = (req_data.action == ACT_HOLD);
               neg_in      = req_data.encoder_count[15];
               mag_in      = req_data.encoder_count[15] ?
                             17'(-$signed({1'b1, req_data.encoder_count})) :
                             {1'b0, req_data.encoder_count};
               track_in    = req_data.track_reference;
               state_in    = ST_MUL_A;
            end
         end
         ST_MUL_A: state_in = ST_MUL_Q;
         ST_MUL_Q: begin
            a_in     = mul_p[31:0];
            state_in = ST_MUL_R;
         end
         ST_MUL_R: begin
            q0_in    = mul_p[63:32];
            state_in = ST_FIX;
         end
         ST_FIX: begin
            angle_in = angle_fix;
            state_in = ST_ERR;
         end
         ST_ERR: begin
            if (run_ff) begin
               ref_in   = ref_sel;
               err_in   = err_calc;
               state_in = ST_MP;
            end else begin
               ref_in   = '0;
               integ_in = '0;
               prev_in  = '0;
               state_in = ST_OUT;
            end
         end
         ST_MP: begin
            integ_in = integ_sat;
            edot_in  = $signed({err_ff[24], err_ff}) - $signed({prev_ff[24], prev_ff});
            prev_in  = err_ff;
            state_in = ST_MI;
         end
         ST_MI: begin
            acc_in   = $signed(mul_p[ACC_W-1:0]);
            state_in = ST_MD;
         end
         ST_MD: begin
            acc_in   = acc_sum;
            state_in = ST_SUM;
         end
         ST_SUM: begin
            held_in  = cmd_sat;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            // hold while the previous result is still stalled
            if (!(rsp_valid_ff && rsp_stall)) begin
               rsp_in.commanded_current = held_ff;
               rsp_in.measured_angle    = angle_ff;
               rsp_in.reference_used    = ref_ff;
               rsp_valid_in             = 1'b1;
               state_in                 = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         integ_ff     <= '0;
         prev_ff      <= '0;
         held_ff      <= '0;
         gain_p_ff    <= 16'sd256;
         gain_i_ff    <= '0;
         gain_d_ff    <= '0;
         hold_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         integ_ff     <= integ_in;
         prev_ff      <= prev_in;
         held_ff      <= held_in;
         if (csr_wr_en) begin
            case (csr_index)
               CSR_GAIN_P:      gain_p_ff <= csr_wdata[15:0];
               CSR_GAIN_I:      gain_i_ff <= csr_wdata[15:0];
               CSR_GAIN_D:      gain_d_ff <= csr_wdata[15:0];
               CSR_HOLD_TARGET: hold_ff   <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      run_ff      <= run_in;
      hold_sel_ff <= hold_sel_in;
      neg_ff      <= neg_in;
      mag_ff      <= mag_in;
      track_ff    <= track_in;
      a_ff        <= a_in;
      q0_ff       <= q0_in;
      angle_ff    <= angle_in;
      ref_ff      <= ref_in;
      err_ff      <= err_in;
      edot_ff     <= edot_in;
      acc_ff      <= acc_in;
      rsp_ff      <= rsp_in;
   end

   a_state_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff))
      else $error("sequencer state is not one-hot");

   a_start: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE && req_valid) |=> (state_ff == ST_MUL_A))
      else $error("accepted transaction did not start the angle scaling");

   a_rsp_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_OUT))
      else $error("result raised outside the output step");

   a_idle_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_OUT && !run_ff) |-> (integ_ff == '0 && prev_ff == '0))
      else $error("idle tick left integral or previous error set");

endmodule

`default_nettype wire
